### design/bur_pkg.sv
// Shared types and constants for the buffered UART ring pair.
package bur_pkg;

   // Ring depths; each ring holds one byte fewer than its depth.
   localparam int TX_DEPTH = 16;
   localparam int RX_DEPTH = 16;
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int BYTE_W   = 8;
   localparam int CMD_W    = 2;
   localparam int ERR_W    = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_HOST_WRITE = 2'd0,
      CMD_HOST_READ  = 2'd1,
      CMD_TX_READY   = 2'd2,
      CMD_RX_BYTE    = 2'd3
   } cmd_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_TX_FULL  = 3'd1,
      ERR_RX_EMPTY = 3'd2,
      ERR_FRAME    = 3'd3,
      ERR_OVERRUN  = 3'd4,
      ERR_PARITY   = 3'd5,
      ERR_RX_FULL  = 3'd6
   } err_type;

   // Store accesses for one request.
   typedef struct packed {
      logic                tx_we;
      logic [TX_PTR_W-1:0] tx_waddr;
      logic                tx_re;
      logic [TX_PTR_W-1:0] tx_raddr;
      logic                rx_we;
      logic [RX_PTR_W-1:0] rx_waddr;
      logic                rx_re;
      logic [RX_PTR_W-1:0] rx_raddr;
   } ram_op_type;

   // Status after one request, captured into the result register.
   typedef struct packed {
      logic             read_hit;
      logic             tx_valid;
      logic             tx_request;
      logic [ERR_W-1:0] error_code;
   } status_type;

endpackage

### design/bur_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bur_ctrl.sv
// Ring pointers, request decode, transmit request flag and the last error code.
module bur_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [bur_pkg::CMD_W-1:0]   command,
   input  logic                        frame_error,
   input  logic                        overrun_error,
   input  logic                        parity_error,
   output bur_pkg::ram_op_type         ram_op,
   output bur_pkg::status_type         status
);
   import bur_pkg::*;

   logic [TX_PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [RX_PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [ERR_W-1:0]    last_error_ff, last_error_in;
   logic                armed_ff, armed_in;
   logic [TX_PTR_W-1:0] tx_head_nx, tx_tail_nx;
   logic [RX_PTR_W-1:0] rx_head_nx, rx_tail_nx;
   logic                tx_empty, tx_full, rx_empty, rx_full;
   cmd_type             cmd;

   // Next pointer positions, wrapping at the ring depth.
   assign tx_head_nx = (tx_head_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_head_ff + 1'b1;
   assign tx_tail_nx = (tx_tail_ff == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_tail_ff + 1'b1;
   assign rx_head_nx = (rx_head_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_head_ff + 1'b1;
   assign rx_tail_nx = (rx_tail_ff == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_tail_ff + 1'b1;

   assign tx_empty = (tx_head_ff == tx_tail_ff);
   assign tx_full  = (tx_head_nx == tx_tail_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign rx_full  = (rx_head_nx == rx_tail_ff);
   assign cmd      = cmd_type'(command);

   // Decode one request into pointer moves, store accesses and status.
   always_comb begin
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      last_error_in = last_error_ff;
      armed_in      = armed_ff;
      ram_op        = '0;
      ram_op.tx_waddr = tx_head_nx;
      ram_op.tx_raddr = tx_tail_nx;
      ram_op.rx_waddr = rx_head_nx;
      ram_op.rx_raddr = rx_tail_nx;
      status        = '0;

      case (cmd)
         CMD_HOST_WRITE: begin
            if (tx_full) begin
               last_error_in = ERR_TX_FULL;
            end else begin
               last_error_in = ERR_NONE;
               tx_head_in    = tx_head_nx;
               armed_in      = 1'b1;
               ram_op.tx_we  = accept;
            end
         end
         CMD_HOST_READ: begin
            if (rx_empty) begin
               last_error_in = ERR_RX_EMPTY;
            end else begin
               last_error_in   = ERR_NONE;
               rx_tail_in      = rx_tail_nx;
               ram_op.rx_re    = accept;
               status.read_hit = 1'b1;
            end
         end
         CMD_TX_READY: begin
            if (tx_empty) begin
               armed_in = 1'b0;
            end else begin
               tx_tail_in      = tx_tail_nx;
               ram_op.tx_re    = accept;
               status.tx_valid = 1'b1;
            end
         end
         CMD_RX_BYTE: begin
            if (rx_full) begin
               last_error_in = ERR_RX_FULL;
            end else begin
               rx_head_in   = rx_head_nx;
               ram_op.rx_we = accept;
               // Line errors are ranked frame, then overrun, then parity.
               if (frame_error) begin
                  last_error_in = ERR_FRAME;
               end else if (overrun_error) begin
                  last_error_in = ERR_OVERRUN;
               end else if (parity_error) begin
                  last_error_in = ERR_PARITY;
               end else begin
                  last_error_in = ERR_NONE;
               end
            end
         end
         default: begin
            last_error_in = last_error_ff;
         end
      endcase

      status.tx_request = armed_in;
      status.error_code = last_error_in;
   end

   // State advances only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         last_error_ff <= ERR_NONE;
         armed_ff      <= 1'b0;
      end else if (accept) begin
         tx_head_ff    <= tx_head_in;
         tx_tail_ff    <= tx_tail_in;
         rx_head_ff    <= rx_head_in;
         rx_tail_ff    <= rx_tail_in;
         last_error_ff <= last_error_in;
         armed_ff      <= armed_in;
      end
   end

endmodule

### design/buffered_uart_ring_pair.sv
// Top level of the buffered UART ring pair: stores, control and result register.
// The result of an accepted request is held in the result register until it is taken.
// Throughput: one request per cycle while the result is not stalled; the result register is refilled as it is taken.
// The store read ports are registered and form part of the result register.
// Reset clears the ring pointers, the error code, the transmit request and result valid.
// The byte stores need no clearing; only written entries are ever read.
module buffered_uart_ring_pair (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bur_pkg::CMD_W-1:0]    req_command,
   input  logic [bur_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                         req_frame_error,
   input  logic                         req_overrun_error,
   input  logic                         req_parity_error,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bur_pkg::BYTE_W-1:0]   rsp_read_data,
   output logic                         rsp_tx_valid,
   output logic [bur_pkg::BYTE_W-1:0]   rsp_tx_data,
   output logic                         rsp_tx_request,
   output logic [bur_pkg::ERR_W-1:0]    rsp_error_code
);
   import bur_pkg::*;

   logic         accept;
   ram_op_type   ram_op;
   status_type   status_in, status_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;

   // A request is taken whenever the result register is free or being emptied.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   bur_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_command),
      .frame_error   (req_frame_error),
      .overrun_error (req_overrun_error),
      .parity_error  (req_parity_error),
      .ram_op        (ram_op),
      .status        (status_in)
   );

   bur_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (ram_op.tx_we),
      .wr_addr (ram_op.tx_waddr),
      .wr_data (req_data_byte),
      .rd_en   (ram_op.tx_re),
      .rd_addr (ram_op.tx_raddr),
      .rd_data (tx_rd_data)
   );

   bur_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (ram_op.rx_we),
      .wr_addr (ram_op.rx_waddr),
      .wr_data (req_data_byte),
      .rd_en   (ram_op.rx_re),
      .rd_addr (ram_op.rx_raddr),
      .rd_data (rx_rd_data)
   );

   // Result register: valid flag and status of the last accepted request.
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // Bytes read zero unless the store was actually read for this request.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = status_ff.read_hit ? rx_rd_data : '0;
   assign rsp_tx_valid   = status_ff.tx_valid;
   assign rsp_tx_data    = status_ff.tx_valid ? tx_rd_data : '0;
   assign rsp_tx_request = status_ff.tx_request;
   assign rsp_error_code = status_ff.error_code;

   // A byte handed to the transmitter leaves the transmit request armed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tx_valid |-> rsp_tx_request)
      else $error("transmit byte issued with request disarmed");

   // A nonzero popped byte only comes from a successful host read.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_read_data != '0) |-> (rsp_error_code == ERR_NONE))
      else $error("read data returned alongside an error code");

   // Every accepted request yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

endmodule
